// ----- src/imbb_pkg.sv -----
// Package for the indexed mesh bounding box block.
// Holds sizes, register indexes, status codes and the float compare helpers.
// No dependencies.
package imbb_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 4096;
  localparam int unsigned TAG_W            = 8;
  localparam int unsigned COUNT_W          = 13;
  localparam int unsigned VCOUNT_W         = 13;
  localparam int unsigned IBYTES_W         = 3;
  localparam int unsigned CFG_ADDR_W       = 1;
  localparam int unsigned CFG_DATA_W       = 13;
  localparam int unsigned STATUS_W         = 3;
  localparam int unsigned WORD_W           = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_VERTEX_COUNT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INDEX_BYTES  = 1'd1;

  localparam logic [IBYTES_W-1:0] IBYTES_RESET = 3'd4;
  localparam logic [IBYTES_W-1:0] IBYTES_ONE   = 3'd1;
  localparam logic [IBYTES_W-1:0] IBYTES_TWO   = 3'd2;
  localparam logic [IBYTES_W-1:0] IBYTES_FOUR  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_VERTS  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_FINITE = 3'd4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef logic [WORD_W-1:0] word_t;

  function automatic logic is_finite(input word_t b);
    return b[30:23] != 8'hFF;
  endfunction

  // Signed ordering key; +0 and -0 map to the same key.
  function automatic logic signed [WORD_W-1:0] order_key(input word_t b);
    logic signed [WORD_W-1:0] mag;
    mag = $signed({1'b0, b[30:0]});
    return b[31] ? -mag : mag;
  endfunction

  function automatic logic less_than(input word_t a, input word_t b);
    return order_key(a) < order_key(b);
  endfunction

endpackage

// ----- src/imbb_if.sv -----
// Handshake channel interfaces for the indexed mesh bounding box block.
// Depends on imbb_pkg.
interface imbb_in_if;
  logic                  valid;
  logic                  ready;
  imbb_pkg::word_t       vertex_index;
  imbb_pkg::word_t       pos_x;
  imbb_pkg::word_t       pos_y;
  imbb_pkg::word_t       pos_z;
  logic                  last;
  modport source (output valid, vertex_index, pos_x, pos_y, pos_z, last, input ready);
  modport sink   (input valid, vertex_index, pos_x, pos_y, pos_z, last, output ready);
endinterface

interface imbb_out_if;
  logic                              valid;
  logic                              ready;
  logic [imbb_pkg::STATUS_W-1:0]     status;
  imbb_pkg::word_t                   out_min_x;
  imbb_pkg::word_t                   out_min_y;
  imbb_pkg::word_t                   out_min_z;
  imbb_pkg::word_t                   out_max_x;
  imbb_pkg::word_t                   out_max_y;
  imbb_pkg::word_t                   out_max_z;
  logic [imbb_pkg::COUNT_W-1:0]      count_referenced;
  logic [imbb_pkg::COUNT_W-1:0]      count_skipped;
  modport source (output valid, status, out_min_x, out_min_y, out_min_z, out_max_x,
                  out_max_y, out_max_z, count_referenced, count_skipped, input ready);
  modport sink   (input valid, status, out_min_x, out_min_y, out_min_z, out_max_x,
                  out_max_y, out_max_z, count_referenced, count_skipped, output ready);
endinterface

interface imbb_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [imbb_pkg::CFG_ADDR_W-1:0]   index;
  logic [imbb_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/imbb_visit_mem.sv -----
// Visited-vertex tag memory: one epoch tag per vertex.
// One write port, one registered read port. Depends on nothing.
module imbb_visit_mem #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/indexed_mesh_bounding_box_core.sv -----
// Top level of the indexed mesh bounding box block.
// Depends on imbb_pkg, the imbb channel interfaces and imbb_visit_mem.
//
// The block takes one index transaction per cycle while in_ch.ready is high.
// Each transaction carries a face index with the already fetched vertex
// position; the transaction with last set closes the list and yields one
// result transaction (status, box and counts), which sits in an output
// register so that intake continues while it waits. Pipeline: in the accept
// cycle the index is masked, range-checked and used to read the visited-tag
// memory; in stage B the tag is compared with the current list epoch (a
// write from the item just ahead is forwarded), and the box, counts and
// error flag are updated. Instead of wiping the bitmap after every list, each
// list has its own 8-bit epoch; the memory is swept to zero after reset and
// once every 255 lists; during the sweep no index transaction is accepted
// (configuration writes are still taken).
module indexed_mesh_bounding_box_core #(
  parameter int unsigned MAX_VERTICES = imbb_pkg::MAX_VERTICES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  imbb_in_if.sink     in_ch,
  imbb_out_if.source  out_ch,
  imbb_cfg_if.sink    cfg
);

  localparam int unsigned IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned TAG_W = imbb_pkg::TAG_W;
  localparam logic [TAG_W-1:0] EPOCH_MAX   = '1;
  localparam logic [TAG_W-1:0] EPOCH_FIRST = TAG_W'(1);
  localparam logic [IDX_W-1:0] LAST_ADDR   = IDX_W'(MAX_VERTICES - 1);
  localparam logic [31:0]      MAX_V32     = 32'(MAX_VERTICES);

  // configuration registers
  logic [imbb_pkg::VCOUNT_W-1:0] vertex_count;
  logic [imbb_pkg::IBYTES_W-1:0] index_bytes;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      index_bytes  <= imbb_pkg::IBYTES_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        imbb_pkg::REG_VERTEX_COUNT: vertex_count <= cfg.data;
        imbb_pkg::REG_INDEX_BYTES:  index_bytes  <= cfg.data[imbb_pkg::IBYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // stage A: accept, mask, range check, tag read
  logic        acc;
  logic        size_ok;
  logic [31:0] idx;
  logic [31:0] limit;
  logic        in_range;

  always_comb begin
    size_ok = (index_bytes == imbb_pkg::IBYTES_ONE) || (index_bytes == imbb_pkg::IBYTES_TWO) ||
              (index_bytes == imbb_pkg::IBYTES_FOUR);
    case (index_bytes)
      imbb_pkg::IBYTES_ONE: idx = {24'd0, in_ch.vertex_index[7:0]};
      imbb_pkg::IBYTES_TWO: idx = {16'd0, in_ch.vertex_index[15:0]};
      default:              idx = in_ch.vertex_index;
    endcase
    limit    = ({19'd0, vertex_count} > MAX_V32) ? MAX_V32 : {19'd0, vertex_count};
    in_range = idx < limit;
  end

  // stage B registers
  logic                  b_valid;
  logic                  b_last;
  logic                  b_size_ok;
  logic                  b_in_range;
  logic                  b_fwd;
  logic [IDX_W-1:0]      b_idx;
  imbb_pkg::word_t       b_px, b_py, b_pz;
  logic                  b_adv;
  logic                  b_take;

  // list state
  logic [TAG_W-1:0]              epoch;
  logic                          clearing;
  logic [IDX_W-1:0]              clr_addr;
  logic                          range_error;
  logic [imbb_pkg::COUNT_W-1:0]  referenced_total, skipped_total;
  imbb_pkg::word_t               lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;

  logic [TAG_W-1:0] rd_tag;

  // B stalls only when it holds a list end and the result register is still full
  assign b_adv = b_valid && !(b_last && out_ch.valid && !out_ch.ready);

  // hold intake while B is stuck, while sweeping, and ahead of an epoch wrap
  assign in_ch.ready = !clearing && !(b_valid && !b_adv) &&
                       !(b_valid && b_last && (epoch == EPOCH_MAX));
  assign acc = in_ch.valid && in_ch.ready;

  imbb_visit_mem #(
    .DEPTH  (MAX_VERTICES),
    .ADDR_W (IDX_W),
    .DATA_W (TAG_W)
  ) u_visit (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (idx[IDX_W-1:0]),
    .rd_data (rd_tag),
    .wr_en   (clearing || b_take),
    .wr_addr (clearing ? clr_addr : b_idx),
    .wr_data (clearing ? '0 : epoch)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (acc) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_last     <= in_ch.last;
      b_size_ok  <= size_ok;
      b_in_range <= in_range;
      b_idx      <= idx[IDX_W-1:0];
      b_px       <= in_ch.pos_x;
      b_py       <= in_ch.pos_y;
      b_pz       <= in_ch.pos_z;
      // the item in B writes its tag at this same edge
      b_fwd      <= b_take && !b_last && (b_idx == idx[IDX_W-1:0]);
    end
  end

  // stage B: visit check and box update
  logic                          visited;
  logic                          finite;
  logic                          err_next;
  logic [imbb_pkg::COUNT_W-1:0]  ref_next, skip_next;
  imbb_pkg::word_t               lo_x_next, lo_y_next, lo_z_next;
  imbb_pkg::word_t               hi_x_next, hi_y_next, hi_z_next;
  logic [imbb_pkg::STATUS_W-1:0] status_next;
  logic                          first;

  always_comb begin
    visited   = b_fwd || (rd_tag == epoch);
    finite    = imbb_pkg::is_finite(b_px) && imbb_pkg::is_finite(b_py) &&
                imbb_pkg::is_finite(b_pz);
    b_take    = b_adv && b_size_ok && !range_error && b_in_range && !visited;
    err_next  = range_error || (b_adv && b_size_ok && !b_in_range);
    first     = referenced_total == '0;
    ref_next  = referenced_total;
    skip_next = skipped_total;
    lo_x_next = lo_x; lo_y_next = lo_y; lo_z_next = lo_z;
    hi_x_next = hi_x; hi_y_next = hi_y; hi_z_next = hi_z;
    if (b_take && !finite) begin
      if (skipped_total != imbb_pkg::COUNT_MAX) skip_next = skipped_total + 1'b1;
    end else if (b_take) begin
      if (referenced_total != imbb_pkg::COUNT_MAX) ref_next = referenced_total + 1'b1;
      if (first || imbb_pkg::less_than(b_px, lo_x)) lo_x_next = b_px;
      if (first || imbb_pkg::less_than(b_py, lo_y)) lo_y_next = b_py;
      if (first || imbb_pkg::less_than(b_pz, lo_z)) lo_z_next = b_pz;
      if (first || imbb_pkg::less_than(hi_x, b_px)) hi_x_next = b_px;
      if (first || imbb_pkg::less_than(hi_y, b_py)) hi_y_next = b_py;
      if (first || imbb_pkg::less_than(hi_z, b_pz)) hi_z_next = b_pz;
    end
    if (vertex_count == '0)    status_next = imbb_pkg::ST_NO_VERTS;
    else if (!b_size_ok)       status_next = imbb_pkg::ST_BAD_SIZE;
    else if (err_next)         status_next = imbb_pkg::ST_RANGE;
    else if (ref_next == '0)   status_next = imbb_pkg::ST_NO_FINITE;
    else                       status_next = imbb_pkg::ST_OK;
  end

  logic list_end;
  assign list_end = b_adv && b_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_error      <= 1'b0;
      referenced_total <= '0;
      skipped_total    <= '0;
      epoch            <= EPOCH_FIRST;
      clearing         <= 1'b1;
      clr_addr         <= '0;
    end else begin
      if (list_end) begin
        range_error      <= 1'b0;
        referenced_total <= '0;
        skipped_total    <= '0;
        if (epoch == EPOCH_MAX) begin
          clearing <= 1'b1;
          clr_addr <= '0;
        end else begin
          epoch <= epoch + 1'b1;
        end
      end else begin
        range_error      <= err_next;
        referenced_total <= ref_next;
        skipped_total    <= skip_next;
      end
      if (clearing) begin
        if (clr_addr == LAST_ADDR) begin
          clearing <= 1'b0;
          epoch    <= EPOCH_FIRST;
        end else begin
          clr_addr <= clr_addr + 1'b1;
        end
      end
    end
  end

  // box bounds carry no reset: only read once a finite vertex has set them
  always_ff @(posedge clk) begin
    lo_x <= lo_x_next; lo_y <= lo_y_next; lo_z <= lo_z_next;
    hi_x <= hi_x_next; hi_y <= hi_y_next; hi_z <= hi_z_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (list_end) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  logic ok;
  assign ok = status_next == imbb_pkg::ST_OK;

  always_ff @(posedge clk) begin
    if (list_end) begin
      out_ch.status           <= status_next;
      out_ch.out_min_x        <= ok ? lo_x_next : '0;
      out_ch.out_min_y        <= ok ? lo_y_next : '0;
      out_ch.out_min_z        <= ok ? lo_z_next : '0;
      out_ch.out_max_x        <= ok ? hi_x_next : '0;
      out_ch.out_max_y        <= ok ? hi_y_next : '0;
      out_ch.out_max_z        <= ok ? hi_z_next : '0;
      out_ch.count_referenced <= ok ? ref_next : '0;
      out_ch.count_skipped    <= ok ? skip_next : '0;
    end
  end

endmodule

// ----- src/imbb_check.sv -----
// Port-level checks for the indexed mesh bounding box block, with its bind.
// Depends on imbb_pkg and indexed_mesh_bounding_box_core.
module imbb_check (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [imbb_pkg::STATUS_W-1:0]      status,
  input logic [imbb_pkg::COUNT_W-1:0]       count_referenced,
  input logic [imbb_pkg::COUNT_W-1:0]       count_skipped,
  input logic                               in_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped while stalled");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && !in_ready)
    else $error("activity right after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != imbb_pkg::ST_OK) |-> count_referenced == '0 && count_skipped == '0)
    else $error("error result carries counts");

  a_ok_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == imbb_pkg::ST_OK) |-> count_referenced != '0)
    else $error("ok result with no referenced vertex");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= imbb_pkg::ST_NO_FINITE)
    else $error("status code out of range");

endmodule

bind indexed_mesh_bounding_box_core imbb_check u_imbb_check (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .status           (out_ch.status),
  .count_referenced (out_ch.count_referenced),
  .count_skipped    (out_ch.count_skipped),
  .in_ready         (in_ch.ready)
);
